// File: design/rfmv_pkg.sv
package rfmv_pkg;

    // Port widths fixed by the word format
    localparam int LABEL_PORT_W = 16;
    localparam int COUNT_PORT_W = 5;
    localparam int IN_TDATA_W   = 16;
    localparam int OUT_TDATA_W  = 24;
    localparam int OUT_PAD_W    = OUT_TDATA_W - LABEL_PORT_W - COUNT_PORT_W;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_INDEX_W  = 3;
    localparam int RIU_W        = 2;

    // Register indexes; range slot r sits at CFG_RANGE_A_LOW + r * CFG_SLOT_STRIDE
    localparam logic [CFG_INDEX_W-1:0] CFG_RANGES_IN_USE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RANGE_A_LOW   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RANGE_A_HIGH  = 3'd2;
    localparam int                     CFG_SLOT_STRIDE   = 2;

    // Register reset values
    localparam logic [RIU_W-1:0]      RANGES_IN_USE_RESET = 2'd1;
    localparam logic [CFG_DATA_W-1:0] RANGE_A_HIGH_RESET  = 16'hFFFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SEARCH,
        ST_COMPARE,
        ST_SCAN_INIT,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_OUT
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic take;
        logic set_ovf;
        logic addr_clr;
        logic addr_inc;
        logic wr_app;
        logic wr_inc;
        logic scan_init;
        logic scan_cmp;
        logic out_load;
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic last;
        logic full;
        logic in_range;
        logic at_end;
        logic match;
        logic out_free;
    } dp_status_t;

endpackage

// File: design/range_filtered_majority_vote_core.sv
// Majority vote over a set of label words, the word with tlast closing the set.
// A word is kept only if its label lies in one of the first ranges_in_use
// inclusive [low, high] ranges; each kept label is looked up in a candidate
// table held in a RAM of MAX_VOTES entries, read one entry at a time. A kept
// word either increments the count of the matching entry or, when it is new,
// is appended to the table. The closing word then starts an argmax walk over
// the candidates and waits while an earlier result still sits in the output
// register; the result is then held in that register, so the next set may
// start while it waits. Ties go to the label seen first; a set with no kept
// word reports label 0 and count 0. Words past MAX_VOTES in a set are ignored
// and flagged in tuser. Only one word is in work at a time; configuration must
// be written only while the block is idle, and the block itself does not
// enforce it.
module range_filtered_majority_vote_core #(
    parameter int MAX_VOTES   = 16,
    parameter int LABEL_BITS  = 16,
    parameter int RANGE_SLOTS = 3
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [rfmv_pkg::IN_TDATA_W-1:0]    s_tdata,   // [15:0] vote_label
    input  logic                               s_tlast,   // last_vote
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [rfmv_pkg::OUT_TDATA_W-1:0]   m_tdata,   // [15:0] winner_label,
                                                          // [20:16] winner_count
    output logic                               m_tuser,   // vote_overflow
    input  logic                               cfg_we,
    input  logic [rfmv_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [rfmv_pkg::CFG_DATA_W-1:0]    cfg_data
);

    import rfmv_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    rfmv_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rfmv_dpath #(
        .MAX_VOTES   (MAX_VOTES),
        .LABEL_BITS  (LABEL_BITS),
        .RANGE_SLOTS (RANGE_SLOTS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// File: design/rfmv_ram.sv
module rfmv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: design/rfmv_ctrl.sv
module rfmv_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  rfmv_pkg::dp_status_t status,
    output rfmv_pkg::dp_cmd_t    cmd
);

    import rfmv_pkg::*;

    state_t state_reg;
    state_t state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequence one word: filter, table walk, then on the closing word the argmax walk
    always_comb
    begin
        state_t after_vote;
        after_vote = status.last ? ST_SCAN_INIT : ST_IDLE;
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.full)
                begin
                    cmd.set_ovf = 1'b1;
                    state_next  = after_vote;
                end
                else
                begin
                    cmd.take = 1'b1;
                    if (status.in_range)
                    begin
                        cmd.addr_clr = 1'b1;
                        state_next   = ST_SEARCH;
                    end
                    else
                    begin
                        state_next = after_vote;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (status.at_end)
                begin
                    cmd.wr_app = 1'b1;
                    state_next = after_vote;
                end
                else
                begin
                    state_next = ST_COMPARE;
                end
            end
            ST_COMPARE:
            begin
                if (status.match)
                begin
                    cmd.wr_inc = 1'b1;
                    state_next = after_vote;
                end
                else
                begin
                    cmd.addr_inc = 1'b1;
                    state_next   = ST_SEARCH;
                end
            end
            ST_SCAN_INIT:
            begin
                cmd.scan_init = 1'b1;
                cmd.addr_clr  = 1'b1;
                state_next    = ST_SCAN_RD;
            end
            ST_SCAN_RD:
            begin
                state_next = status.at_end ? ST_OUT : ST_SCAN_CMP;
            end
            ST_SCAN_CMP:
            begin
                cmd.scan_cmp = 1'b1;
                cmd.addr_inc = 1'b1;
                state_next   = ST_SCAN_RD;
            end
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: design/rfmv_dpath.sv
module rfmv_dpath #(
    parameter int MAX_VOTES   = 16,
    parameter int LABEL_BITS  = 16,
    parameter int RANGE_SLOTS = 3
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [rfmv_pkg::IN_TDATA_W-1:0]       s_tdata,
    input  logic                                  s_tlast,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [rfmv_pkg::OUT_TDATA_W-1:0]      m_tdata,
    output logic                                  m_tuser,
    input  logic                                  cfg_we,
    input  logic [rfmv_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [rfmv_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  rfmv_pkg::dp_cmd_t                     cmd,
    output rfmv_pkg::dp_status_t                  status
);

    import rfmv_pkg::*;

    localparam int LW = (LABEL_BITS < LABEL_PORT_W) ? LABEL_BITS : LABEL_PORT_W;
    localparam int AW = $clog2(MAX_VOTES);
    localparam int CW = $clog2(MAX_VOTES + 1);
    localparam int EW = LW + CW;

    logic [RIU_W-1:0]        riu_reg;
    logic [RANGE_SLOTS-1:0]  slot_hit;

    logic [LW-1:0] label_reg, label_next;
    logic          last_reg, last_next;
    logic [CW-1:0] held_reg, held_next;
    logic [CW-1:0] taken_reg, taken_next;
    logic          ovf_reg, ovf_next;
    logic [CW-1:0] addr_reg, addr_next;
    logic [CW-1:0] best_cnt_reg, best_cnt_next;
    logic [LW-1:0] best_lbl_reg, best_lbl_next;
    logic          out_valid_reg, out_valid_next;
    logic [LABEL_PORT_W-1:0] out_label_reg, out_label_next;
    logic [COUNT_PORT_W-1:0] out_count_reg, out_count_next;
    logic          out_ovf_reg, out_ovf_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    logic [EW-1:0] ram_rdata;
    logic [LW-1:0] rd_label;
    logic [CW-1:0] rd_count;

    // Count of enabled ranges
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            riu_reg <= RANGES_IN_USE_RESET;
        end
        else if (cfg_we && cfg_index == CFG_RANGES_IN_USE)
        begin
            riu_reg <= cfg_data[RIU_W-1:0];
        end
    end

    // One bound pair per range slot; a slot beyond the enabled count never hits
    for (genvar r = 0; r < RANGE_SLOTS; r++)
    begin : g_slot
        localparam logic [CFG_INDEX_W-1:0] LO_IDX =
            CFG_RANGE_A_LOW + CFG_INDEX_W'(r * CFG_SLOT_STRIDE);
        localparam logic [CFG_INDEX_W-1:0] HI_IDX =
            CFG_RANGE_A_HIGH + CFG_INDEX_W'(r * CFG_SLOT_STRIDE);
        localparam logic [CFG_DATA_W-1:0] HI_RESET = (r == 0) ? RANGE_A_HIGH_RESET : '0;

        logic [CFG_DATA_W-1:0] lo_reg;
        logic [CFG_DATA_W-1:0] hi_reg;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                lo_reg <= '0;
                hi_reg <= HI_RESET;
            end
            else if (cfg_we)
            begin
                if (cfg_index == LO_IDX)
                begin
                    lo_reg <= cfg_data;
                end
                if (cfg_index == HI_IDX)
                begin
                    hi_reg <= cfg_data;
                end
            end
        end

        assign slot_hit[r] = (riu_reg > RIU_W'(r))
                          && (CFG_DATA_W'(label_reg) >= lo_reg)
                          && (CFG_DATA_W'(label_reg) <= hi_reg);
    end

    // Candidate table: label above count in each entry
    rfmv_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_VOTES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (addr_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign rd_label  = ram_rdata[EW-1:CW];
    assign rd_count  = ram_rdata[CW-1:0];
    assign ram_we    = cmd.wr_app || cmd.wr_inc;
    assign ram_waddr = cmd.wr_app ? held_reg[AW-1:0] : addr_reg[AW-1:0];
    assign ram_wdata = {label_reg, cmd.wr_app ? CW'(1) : rd_count + CW'(1)};

    // Report status to the controller
    always_comb
    begin
        status          = '0;
        status.last     = last_reg;
        status.full     = (taken_reg >= CW'(MAX_VOTES));
        status.in_range = |slot_hit;
        status.at_end   = (addr_reg == held_reg);
        status.match    = (rd_label == label_reg);
        status.out_free = !out_valid_reg || m_tready;
    end

    // Work out the next register values from the commands
    always_comb
    begin
        label_next     = label_reg;
        last_next      = last_reg;
        held_next      = held_reg;
        taken_next     = taken_reg;
        ovf_next       = ovf_reg;
        addr_next      = addr_reg;
        best_cnt_next  = best_cnt_reg;
        best_lbl_next  = best_lbl_reg;
        out_valid_next = out_valid_reg;
        out_label_next = out_label_reg;
        out_count_next = out_count_reg;
        out_ovf_next   = out_ovf_reg;

        if (cmd.load)
        begin
            label_next = s_tdata[LW-1:0];
            last_next  = s_tlast;
        end
        if (cmd.take)
        begin
            taken_next = taken_reg + CW'(1);
        end
        if (cmd.set_ovf)
        begin
            ovf_next = 1'b1;
        end
        if (cmd.addr_clr)
        begin
            addr_next = '0;
        end
        else if (cmd.addr_inc)
        begin
            addr_next = addr_reg + CW'(1);
        end
        if (cmd.wr_app)
        begin
            held_next = held_reg + CW'(1);
        end
        if (cmd.scan_init)
        begin
            best_cnt_next = '0;
            best_lbl_next = '0;
        end
        // Strict compare keeps the earliest candidate on a tie
        if (cmd.scan_cmp && rd_count > best_cnt_reg)
        begin
            best_cnt_next = rd_count;
            best_lbl_next = rd_label;
        end
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        // Publish the result and clear the set
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
            out_label_next = LABEL_PORT_W'(best_lbl_reg);
            out_count_next = COUNT_PORT_W'(best_cnt_reg);
            out_ovf_next   = ovf_reg;
            held_next      = '0;
            taken_next     = '0;
            ovf_next       = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= '0;
            taken_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            held_reg      <= held_next;
            taken_reg     <= taken_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        label_reg     <= label_next;
        last_reg      <= last_next;
        addr_reg      <= addr_next;
        best_cnt_reg  <= best_cnt_next;
        best_lbl_reg  <= best_lbl_next;
        out_label_reg <= out_label_next;
        out_count_reg <= out_count_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_count_reg, out_label_reg};
    assign m_tuser  = out_ovf_reg;

endmodule

// File: design/rfmv_checker.sv
module rfmv_checker #(
    parameter int MAX_VOTES = 16
) (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [rfmv_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input logic                               m_tuser
);

    // A stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // One word in work at a time: no accept right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a word is in work");

    // An empty set reports label zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (MAX_VOTES < 32) && m_tvalid && m_tdata[20:16] == 5'd0 |-> m_tdata[15:0] == 16'd0)
        else $error("zero count with a nonzero label");

    // The winning count never exceeds the set capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        (MAX_VOTES < 32) && m_tvalid |-> m_tdata[20:16] <= 5'(MAX_VOTES))
        else $error("winner count beyond capacity");

endmodule

bind range_filtered_majority_vote_core rfmv_checker #(.MAX_VOTES(MAX_VOTES)) u_rfmv_checker (.*);

// File: verif/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rfmv_pkg::*;

    localparam int MAX_VOTES     = 16;
    localparam int LABEL_BITS    = 16;
    localparam int RANGE_SLOTS   = 3;
    localparam int SETTLE_CYCLES = 100;
    localparam int STALL_LIMIT   = 4000;
    localparam int PHASE_WORDS   = 240;
    localparam int RANDOM_PHASES = 8;

    typedef struct packed {
        logic [LABEL_PORT_W-1:0] label;
        logic                    closes;
    } vote_t;

    typedef struct packed {
        logic [LABEL_PORT_W-1:0] label;
        logic [COUNT_PORT_W-1:0] count;
        logic                    overflow;
    } winner_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [IN_TDATA_W-1:0]   s_tdata = '0;
    logic                    s_tlast = 1'b0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_tdata;
    logic                    m_tuser;
    logic                    cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;

    // Words waiting to be sent and winners still owed by the block
    vote_t   vote_q[$];
    winner_t winner_q[$];
    vote_t   next_vote;

    // Our copy of the range registers
    logic [RIU_W-1:0]        rng_used = RANGES_IN_USE_RESET;
    logic [CFG_DATA_W-1:0]   rng_low  [RANGE_SLOTS] = '{default: '0};
    logic [CFG_DATA_W-1:0]   rng_high [RANGE_SLOTS] = '{RANGE_A_HIGH_RESET, 16'h0, 16'h0};

    // Tally of the set in progress
    logic [LABEL_PORT_W-1:0] held_label [MAX_VOTES];
    int                      held_count [MAX_VOTES];
    int                      labels_held = 0;
    int                      votes_in_set = 0;
    logic                    set_overflowed = 1'b0;

    bit word_taken = 1'b0;
    bit result_taken = 1'b0;
    int words_queued = 0;
    int words_accepted = 0;
    int idle_cycles = 0;
    int mismatches = 0;
    int tx_gap = 0;
    int rx_stall = 0;
    int calm_left [2] = '{0, 0};
    int sets_closed = 0;
    int sets_overflowed = 0;
    int sets_empty = 0;
    int settings_used = 1;

    range_filtered_majority_vote_core #(
        .MAX_VOTES   (MAX_VOTES),
        .LABEL_BITS  (LABEL_BITS),
        .RANGE_SLOTS (RANGE_SLOTS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Pause length: mostly none or short, now and then long, with calm stretches
    function automatic int pick_pause(input int side);
        int r;
        if (calm_left[side] > 0)
        begin
            calm_left[side]--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2)
        begin
            calm_left[side] = $urandom_range(20, 80);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic bit label_kept(input logic [LABEL_PORT_W-1:0] label);
        int used;
        used = (int'(rng_used) > RANGE_SLOTS) ? RANGE_SLOTS : int'(rng_used);
        for (int r = 0; r < used; r++)
            if (label >= rng_low[r] && label <= rng_high[r])
                return 1'b1;
        return 1'b0;
    endfunction

    // Fold one accepted word into the tally; on the closing word, owe a winner
    task automatic count_vote(input logic [LABEL_PORT_W-1:0] label, input logic closes);
        bit      found;
        int      best;
        winner_t win;
        if (votes_in_set >= MAX_VOTES)
            set_overflowed = 1'b1;
        else
        begin
            votes_in_set++;
            if (label_kept(label))
            begin
                found = 1'b0;
                for (int j = 0; j < labels_held; j++)
                begin
                    if (held_label[j] == label)
                    begin
                        held_count[j]++;
                        found = 1'b1;
                    end
                end
                if (!found && labels_held < MAX_VOTES)
                begin
                    held_label[labels_held] = label;
                    held_count[labels_held] = 1;
                    labels_held++;
                end
            end
        end
        if (closes)
        begin
            best = 0;
            win.label = '0;
            // Strictly greater, so the earliest label keeps a tie
            for (int j = 0; j < labels_held; j++)
            begin
                if (held_count[j] > best)
                begin
                    best = held_count[j];
                    win.label = held_label[j];
                end
            end
            win.count = COUNT_PORT_W'(best);
            win.overflow = set_overflowed;
            winner_q = {winner_q, win};
            sets_closed++;
            if (set_overflowed)
                sets_overflowed++;
            if (best == 0)
                sets_empty++;
            labels_held = 0;
            votes_in_set = 0;
            set_overflowed = 1'b0;
        end
    endtask

    task automatic note_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
    endtask

    task automatic check_winner();
        winner_t want;
        if (winner_q.size() == 0)
        begin
            note_mismatch("winner with none outstanding, label", 0, m_tdata[LABEL_PORT_W-1:0]);
            return;
        end
        want = winner_q.pop_front();
        if (m_tdata[LABEL_PORT_W-1:0] !== want.label)
            note_mismatch("winner_label", want.label, m_tdata[LABEL_PORT_W-1:0]);
        if (m_tdata[LABEL_PORT_W +: COUNT_PORT_W] !== want.count)
            note_mismatch("winner_count", want.count, m_tdata[LABEL_PORT_W +: COUNT_PORT_W]);
        if (m_tuser !== want.overflow)
            note_mismatch("vote_overflow", want.overflow, m_tuser);
    endtask

    // Sample both handshakes at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            word_taken = s_tvalid && s_tready;
            result_taken = m_tvalid && m_tready;
            if (word_taken)
            begin
                words_accepted++;
                count_vote(s_tdata[LABEL_PORT_W-1:0], s_tlast);
            end
            if (result_taken)
                check_winner();
            if (word_taken || result_taken || cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    // Send vote words; hold the current word until it is taken
    always @(negedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || word_taken)
        begin
            if (tx_gap > 0)
            begin
                s_tvalid <= 1'b0;
                tx_gap--;
            end
            else if (vote_q.size() != 0)
            begin
                next_vote = vote_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= next_vote.label;
                s_tlast  <= next_vote.closes;
                tx_gap = pick_pause(0);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Stall the result side at random
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (rx_stall > 0)
        begin
            m_tready <= 1'b0;
            rx_stall--;
        end
        else
        begin
            rx_stall = pick_pause(1);
            m_tready <= (rx_stall == 0);
        end
    end

    task automatic queue_vote(input logic [LABEL_PORT_W-1:0] label, input logic closes);
        vote_t v;
        v.label = label;
        v.closes = closes;
        vote_q = {vote_q, v};
        words_queued++;
    endtask

    // Hold off until every word is taken and every winner is in, then let the block settle
    task automatic wait_quiet();
        while (words_accepted != words_queued || winner_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
    endtask

    task automatic end_writes();
        @(negedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic write_used(input logic [RIU_W-1:0] used, input bit junk);
        logic [CFG_DATA_W-1:0] value;
        value = junk ? CFG_DATA_W'($urandom) : '0;
        value[RIU_W-1:0] = used;
        write_reg(CFG_RANGES_IN_USE, value);
        rng_used = used;
    endtask

    task automatic write_range(input int slot, input logic [CFG_DATA_W-1:0] lo,
                               input logic [CFG_DATA_W-1:0] hi);
        write_reg(CFG_INDEX_W'(CFG_RANGE_A_LOW + slot * CFG_SLOT_STRIDE), lo);
        write_reg(CFG_INDEX_W'(CFG_RANGE_A_HIGH + slot * CFG_SLOT_STRIDE), hi);
        rng_low[slot] = lo;
        rng_high[slot] = hi;
    endtask

    // New range setting; style 0 opens everything, style 1 disables all ranges
    task automatic set_random_ranges(input int style);
        logic [CFG_DATA_W-1:0] lo;
        logic [CFG_DATA_W-1:0] hi;
        logic [RIU_W-1:0]      used;
        for (int slot = 0; slot < RANGE_SLOTS; slot++)
        begin
            case ($urandom_range(0, 9))
                0: begin lo = '0; hi = '1; end
                1: begin lo = CFG_DATA_W'($urandom_range(1, 65535));
                         hi = CFG_DATA_W'($urandom_range(0, lo - 1)); end
                2: begin lo = CFG_DATA_W'($urandom); hi = lo; end
                3: begin lo = CFG_DATA_W'($urandom); hi = '1; end
                4: begin lo = '0; hi = CFG_DATA_W'($urandom); end
                default:
                begin
                    lo = CFG_DATA_W'($urandom);
                    hi = (int'(lo) + 2000 > 65535) ? '1
                         : CFG_DATA_W'($urandom_range(lo, lo + 2000));
                end
            endcase
            if (style == 0 && slot == 0)
            begin
                lo = '0;
                hi = '1;
            end
            write_range(slot, lo, hi);
        end
        case (style)
            0: used = 2'd1;
            1: used = 2'd0;
            2: used = 2'd3;
            default: used = RIU_W'($urandom_range(1, 3));
        endcase
        write_used(used, $urandom_range(0, 1));
        end_writes();
    endtask

    // One set drawn from a small pool of labels near the configured ranges, with noise
    task automatic queue_random_set();
        logic [LABEL_PORT_W-1:0] pool [5];
        logic [LABEL_PORT_W-1:0] label;
        logic [CFG_DATA_W-1:0]   lo;
        logic [CFG_DATA_W-1:0]   hi;
        int k, len, r, slot, i, j;
        k = $urandom_range(1, 5);
        for (int n = 0; n < k; n++)
        begin
            slot = $urandom_range(0, RANGE_SLOTS - 1);
            lo = rng_low[slot];
            hi = rng_high[slot];
            case ($urandom_range(0, 7))
                0: pool[n] = lo;
                1: pool[n] = hi;
                2: pool[n] = lo - 16'd1;
                3: pool[n] = hi + 16'd1;
                7: pool[n] = LABEL_PORT_W'($urandom);
                default: pool[n] = (lo <= hi) ? LABEL_PORT_W'($urandom_range(hi, lo))
                                              : LABEL_PORT_W'($urandom);
            endcase
        end
        r = $urandom_range(0, 99);
        if (r < 10)
            len = $urandom_range(MAX_VOTES + 1, MAX_VOTES + 8);
        else if (r < 15)
            len = MAX_VOTES;
        else if (r < 20)
            len = 1;
        else
            len = $urandom_range(2, MAX_VOTES - 1);
        for (int n = 0; n < len; n++)
        begin
            // Lean towards the first pool entries so that one label tends to lead
            i = $urandom_range(0, k - 1);
            j = $urandom_range(0, k - 1);
            if ($urandom_range(0, 99) < 15)
                label = LABEL_PORT_W'($urandom);
            else
                label = pool[(i < j) ? i : j];
            queue_vote(label, n == len - 1);
        end
    endtask

    // Stall watchdog
    initial
    begin
        wait (rst_n === 1'b1);
        while (idle_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("Watchdog: no handshake for %0d cycles", STALL_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        int start;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset ranges: extremes of the label, first-seen tie break, full table with overflow
        queue_vote(16'hFFFF, 1'b0);
        queue_vote(16'h0000, 1'b0);
        queue_vote(16'hFFFF, 1'b1);
        queue_vote(16'd5, 1'b0);
        queue_vote(16'd7, 1'b0);
        queue_vote(16'd7, 1'b0);
        queue_vote(16'd5, 1'b1);
        for (int n = 0; n <= MAX_VOTES; n++)
            queue_vote(LABEL_PORT_W'(n * 3851 + 1), n == MAX_VOTES);
        wait_quiet();

        // No range enabled: the set reports nothing kept
        write_used(2'd0, 1'b0);
        end_writes();
        queue_vote(16'd100, 1'b1);
        wait_quiet();

        // Empty first range, single-label second and third ranges at the edges
        write_range(0, 16'd10, 16'd5);
        write_range(1, 16'hFFFF, 16'hFFFF);
        write_range(2, 16'h0000, 16'h0000);
        write_used(2'd3, 1'b0);
        end_writes();
        queue_vote(16'hFFFF, 1'b0);
        queue_vote(16'd8, 1'b0);
        queue_vote(16'h0000, 1'b0);
        queue_vote(16'hFFFF, 1'b1);
        queue_vote(16'd10, 1'b1);
        wait_quiet();

        // Random phases, each under its own range setting
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            set_random_ranges(p);
            start = words_queued;
            while (words_queued - start < PHASE_WORDS)
                queue_random_set();
            wait_quiet();
        end

        $display("Run covered %0d vote words in %0d sets under %0d range settings;",
                 words_accepted, sets_closed, settings_used);
        $display("%0d sets overflowed and %0d sets kept no vote.", sets_overflowed, sets_empty);
        if (mismatches == 0 && winner_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
